[design/bsb_pkg.sv]
// shared constants and types for the b-spline basis evaluator
package bsb_pkg;

   localparam int DEF_MAX_KNOTS     = 32;
   localparam int DEF_MAX_DEGREE    = 3;
   localparam int DEF_FRACTION_BITS = 16;
   localparam int DEF_DIV_NUM_W     = 63;
   localparam int DEF_DIV_DEN_W     = 33;

   localparam int NB_W = 31;
   localparam logic [NB_W-1:0] ONE_Q30 = 31'h4000_0000;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic CSR_DEGREE     = 1'b0;
   localparam logic CSR_KNOT_COUNT = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_FILL  = 16'h0002,
      S_FETCH = 16'h0004,
      S_DIFF  = 16'h0008,
      S_W1    = 16'h0010,
      S_W1W   = 16'h0020,
      S_W2    = 16'h0040,
      S_W2W   = 16'h0080,
      S_MUL   = 16'h0100,
      S_SUM   = 16'h0200,
      S_DT1   = 16'h0400,
      S_DT1W  = 16'h0800,
      S_DT2   = 16'h1000,
      S_DT2W  = 16'h2000,
      S_SAT   = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

endpackage

[design/bsb_cell.sv]
// one basis value cell of the rotating triangle chain
module bsb_cell (
   input  logic                      clock,
   input  logic                      shift_en,
   input  logic [bsb_pkg::NB_W:0]    din,
   output logic [bsb_pkg::NB_W-1:0]  dout
);
   import bsb_pkg::*;

   logic [NB_W-1:0] val_ff;

   // clamp at 1.0 on the way in
   always_ff @(posedge clock) begin
      if (shift_en) begin
         if (din > {1'b0, ONE_Q30}) begin
            val_ff <= ONE_Q30;
         end else begin
            val_ff <= din[NB_W-1:0];
         end
      end
   end

   assign dout = val_ff;

endmodule

[design/bsb_div.sv]
// bit-serial restoring unsigned divider, one quotient bit per cycle
module bsb_div #(
   parameter int NUM_W = bsb_pkg::DEF_DIV_NUM_W,
   parameter int DEN_W = bsb_pkg::DEF_DIV_DEN_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output bsb_pkg::div_stat_type stat,
   output logic [NUM_W-1:0]     quot
);
   import bsb_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      rem_in  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= CW'(NUM_W);
            rem_ff  <= '0;
            num_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
            q_ff    <= {q_ff[NUM_W-2:0], ge};
            cnt_ff  <= cnt_ff - CW'(1);
            done_ff <= (cnt_ff == CW'(1));
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

[design/bspline_basis_and_derivative.sv]
// b-spline basis value and derivative evaluator, cox-de boor over a rotating cell chain
// load beat: taken while idle, no result. index error: the beat goes straight to done, then
// the result register takes the error result. evaluate: a fill pass, then per level
// MAX_DEGREE+2 chain steps; a term step fetches four knots and forms two weights with passes
// of the shared bit-serial divider (skipped for a weight of zero or one), a rotate step only
// shifts the chain; the derivative adds two more divider passes. one item in flight at a time.
// reset clears control, sets degree 3 and knot_count 32; the knot table is not cleared.
module bspline_basis_and_derivative #(
   parameter int MAX_KNOTS     = bsb_pkg::DEF_MAX_KNOTS,
   parameter int MAX_DEGREE    = bsb_pkg::DEF_MAX_DEGREE,
   parameter int FRACTION_BITS = bsb_pkg::DEF_FRACTION_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [4:0]         req_knot_slot,
   input  logic signed [31:0] req_knot_value,
   input  logic [4:0]         req_basis_index,
   input  logic signed [31:0] req_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_basis_value,
   output logic signed [31:0] rsp_derivative_value,
   output logic               rsp_derivative_saturated,
   output logic               rsp_index_error,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [5:0]         csr_write_data
);
   import bsb_pkg::*;

   localparam int L      = MAX_DEGREE + 2;
   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
   localparam int KA_W   = $clog2(MAX_KNOTS);
   localparam int CNT_W  = $clog2(L + 2);
   localparam int S_W    = $clog2(L);
   localparam int SHL    = 2 * FRACTION_BITS - 30;
   localparam int SHLP   = (SHL > 0) ? SHL : 0;
   localparam int SHLN   = (SHL < 0) ? -SHL : 0;
   localparam int DNUM_W = (34 + SHLP > 63) ? 34 + SHLP : 63;
   localparam int DDEN_W = 33 + SHLN;
   localparam int FETCH_LAST = 4;
   localparam logic signed [DNUM_W+1:0] DMAX = (DNUM_W+2)'($signed(32'h7fff_ffff));
   localparam logic signed [DNUM_W+1:0] DMIN = (DNUM_W+2)'($signed(32'h8000_0000));

   state_type state_ff, state_in;

   logic [1:0]  degree_ff;
   logic [5:0]  kcount_ff;

   logic signed [31:0] knot_mem [MAX_KNOTS];
   logic signed [31:0] rd_data_ff;
   logic [KA_W-1:0]    rd_addr;

   logic [4:0]         idx_ff;
   logic signed [31:0] u_ff;
   logic [DEG_W-1:0]   p_ff;
   logic               err_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [S_W-1:0]     s_ff;
   logic [DEG_W-1:0]   d_ff;
   logic signed [31:0] prevk_ff;
   logic signed [31:0] ka_ff, kb_ff, kc_ff, ke_ff;
   logic signed [32:0] num1_ff, den1_ff, num2_ff, den2_ff, dden1_ff, dden2_ff;
   logic [NB_W-1:0]    w1_ff, w2_ff, prev0_ff, prev1_ff;
   logic [61:0]        p1_ff, p2_ff;
   logic signed [DNUM_W:0] t1_ff, t2_ff;
   logic [31:0]        dval_ff;
   logic               dsat_ff;

   logic               rsp_valid_ff;
   logic [30:0]        rsp_basis_ff;
   logic [31:0]        rsp_deriv_ff;
   logic               rsp_sat_ff;
   logic               rsp_err_ff;

   logic [NB_W-1:0]    cell_q [L];
   logic [NB_W:0]      tail_in;
   logic               shift_en;
   logic               step_done;

   logic               div_start;
   logic [DNUM_W-1:0]  div_num;
   logic [DDEN_W-1:0]  div_den;
   logic [DNUM_W-1:0]  div_q;
   div_stat_type       div_stat;

   logic               acc;
   logic [DEG_W-1:0]   p_now;
   logic               err_now;
   logic               active;
   logic               ind;
   logic signed [32:0] wn, wd;
   logic [32:0]        wn_abs, wd_abs;
   logic               w_zero, w_one;
   logic signed [32:0] dd;
   logic [32:0]        dd_abs;
   logic [33:0]        dprod;
   logic [NB_W-1:0]    dprev;
   logic signed [DNUM_W:0]   tq;
   logic signed [DNUM_W+1:0] diff;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      int kc_i;
      p_now   = DEG_W'((int'(degree_ff) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_ff));
      kc_i    = (int'(kcount_ff) > MAX_KNOTS) ? MAX_KNOTS : int'(kcount_ff);
      err_now = (int'(req_basis_index) + int'(p_now) + 1) >= kc_i;
      active  = (int'(s_ff) + int'(d_ff)) <= int'(p_ff);
      ind     = ((int'(cnt_ff) - 2) <= int'(p_ff)) && (prevk_ff <= u_ff) && (u_ff < rd_data_ff);

      wn = (state_ff == S_W1) ? num1_ff : num2_ff;
      wd = (state_ff == S_W1) ? den1_ff : den2_ff;
      wn_abs = wn[32] ? 33'(-wn) : 33'(wn);
      wd_abs = wd[32] ? 33'(-wd) : 33'(wd);
      w_zero = (wd == '0) || (wn == '0) || (wn[32] != wd[32]);
      w_one  = wn_abs >= wd_abs;

      dd     = (state_ff == S_DT1) ? dden1_ff : dden2_ff;
      dprev  = (state_ff == S_DT1) ? prev0_ff : prev1_ff;
      dd_abs = dd[32] ? 33'(-dd) : 33'(dd);
      dprod  = 34'(p_ff) * 34'(dprev);
      tq     = $signed({1'b0, div_q});
      diff   = (DNUM_W+2)'(t1_ff) - (DNUM_W+2)'(t2_ff);
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      shift_en  = 1'b0;
      tail_in   = '0;
      rd_addr   = KA_W'(idx_ff);
      step_done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_action == ACT_EVAL) begin
               state_in = err_now ? S_DONE : S_FILL;
            end
         end
         S_FILL: begin
            rd_addr = KA_W'(int'(idx_ff) + int'(cnt_ff));
            if (cnt_ff >= CNT_W'(2)) begin
               shift_en = 1'b1;
               tail_in  = ind ? {1'b0, ONE_Q30} : '0;
            end
            if (cnt_ff == CNT_W'(L + 1)) begin
               state_in = (p_ff == '0) ? S_DONE : S_FETCH;
            end
         end
         S_FETCH: begin
            unique case (cnt_ff)
               CNT_W'(1): rd_addr = KA_W'(int'(idx_ff) + int'(s_ff) + int'(d_ff));
               CNT_W'(2): rd_addr = KA_W'(int'(idx_ff) + int'(s_ff) + 1);
               CNT_W'(3): rd_addr = KA_W'(int'(idx_ff) + int'(s_ff) + int'(d_ff) + 1);
               default:   rd_addr = KA_W'(int'(idx_ff) + int'(s_ff));
            endcase
            if (cnt_ff == '0 && !active) begin
               shift_en  = 1'b1;
               tail_in   = {1'b0, cell_q[0]};
               step_done = 1'b1;
            end else if (cnt_ff == CNT_W'(FETCH_LAST)) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: state_in = S_W1;
         S_W1, S_W2: begin
            if (w_zero || w_one) begin
               state_in = (state_ff == S_W1) ? S_W2 : S_MUL;
            end else begin
               div_start = 1'b1;
               div_num   = DNUM_W'({wn_abs, 30'b0});
               div_den   = DDEN_W'(wd_abs);
               state_in  = (state_ff == S_W1) ? S_W1W : S_W2W;
            end
         end
         S_W1W: if (div_stat.done) state_in = S_W2;
         S_W2W: if (div_stat.done) state_in = S_MUL;
         S_MUL: state_in = S_SUM;
         S_SUM: begin
            shift_en  = 1'b1;
            tail_in   = {1'b0, p1_ff[60:30]} + {1'b0, p2_ff[60:30]};
            step_done = 1'b1;
         end
         S_DT1, S_DT2: begin
            if (dd == '0) begin
               state_in = (state_ff == S_DT1) ? S_DT2 : S_SAT;
            end else begin
               div_start = 1'b1;
               div_num   = DNUM_W'(dprod) << SHLP;
               div_den   = DDEN_W'(dd_abs) << SHLN;
               state_in  = (state_ff == S_DT1) ? S_DT1W : S_DT2W;
            end
         end
         S_DT1W: if (div_stat.done) state_in = S_DT2;
         S_DT2W: if (div_stat.done) state_in = S_SAT;
         S_SAT:  state_in = S_DONE;
         S_DONE: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (step_done) begin
         if (s_ff == S_W'(L - 1) && d_ff == p_ff) begin
            state_in = S_DT1;
         end else begin
            state_in = S_FETCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         degree_ff <= 2'd3;
         kcount_ff <= 6'd32;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEGREE:     degree_ff <= csr_write_data[1:0];
               CSR_KNOT_COUNT: kcount_ff <= csr_write_data;
               default:        degree_ff <= degree_ff;
            endcase
         end
      end
   end

   // knot table
   always_ff @(posedge clock) begin
      if (acc && req_action == ACT_LOAD && int'(req_knot_slot) < MAX_KNOTS) begin
         knot_mem[KA_W'(req_knot_slot)] <= req_knot_value;
      end
      rd_data_ff <= knot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (acc && req_action == ACT_EVAL) begin
               idx_ff  <= req_basis_index;
               u_ff    <= req_point;
               p_ff    <= p_now;
               err_ff  <= err_now;
               cnt_ff  <= '0;
               s_ff    <= '0;
               d_ff    <= DEG_W'(1);
               dval_ff <= '0;
               dsat_ff <= 1'b0;
            end
         end
         S_FILL: begin
            prevk_ff <= rd_data_ff;
            cnt_ff   <= (cnt_ff == CNT_W'(L + 1)) ? '0 : cnt_ff + CNT_W'(1);
         end
         S_FETCH: begin
            if (!step_done) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            unique case (cnt_ff)
               CNT_W'(1): ka_ff <= rd_data_ff;
               CNT_W'(2): kb_ff <= rd_data_ff;
               CNT_W'(3): kc_ff <= rd_data_ff;
               CNT_W'(4): ke_ff <= rd_data_ff;
               default:   ka_ff <= ka_ff;
            endcase
         end
         S_DIFF: begin
            cnt_ff  <= '0;
            num1_ff <= {u_ff[31], u_ff} - {ka_ff[31], ka_ff};
            den1_ff <= {kb_ff[31], kb_ff} - {ka_ff[31], ka_ff};
            num2_ff <= {ke_ff[31], ke_ff} - {u_ff[31], u_ff};
            den2_ff <= {ke_ff[31], ke_ff} - {kc_ff[31], kc_ff};
            if (d_ff == p_ff && s_ff == '0) begin
               dden1_ff <= {kb_ff[31], kb_ff} - {ka_ff[31], ka_ff};
               dden2_ff <= {ke_ff[31], ke_ff} - {kc_ff[31], kc_ff};
               prev0_ff <= cell_q[0];
               prev1_ff <= cell_q[1];
            end
         end
         S_W1:  w1_ff <= w_zero ? '0 : ONE_Q30;
         S_W2:  w2_ff <= w_zero ? '0 : ONE_Q30;
         S_W1W: if (div_stat.done) w1_ff <= div_q[NB_W-1:0];
         S_W2W: if (div_stat.done) w2_ff <= div_q[NB_W-1:0];
         S_MUL: begin
            p1_ff <= w1_ff * cell_q[0];
            p2_ff <= w2_ff * cell_q[1];
         end
         S_DT1:  t1_ff <= '0;
         S_DT2:  t2_ff <= '0;
         S_DT1W: if (div_stat.done) t1_ff <= dden1_ff[32] ? -tq : tq;
         S_DT2W: if (div_stat.done) t2_ff <= dden2_ff[32] ? -tq : tq;
         S_SAT: begin
            if (diff > DMAX) begin
               dval_ff <= 32'h7fff_ffff;
               dsat_ff <= 1'b1;
            end else if (diff < DMIN) begin
               dval_ff <= 32'h8000_0000;
               dsat_ff <= 1'b1;
            end else begin
               dval_ff <= diff[31:0];
               dsat_ff <= 1'b0;
            end
         end
         default: ;
      endcase
      if (step_done) begin
         cnt_ff <= '0;
         if (s_ff == S_W'(L - 1)) begin
            s_ff <= '0;
            d_ff <= d_ff + DEG_W'(1);
         end else begin
            s_ff <= s_ff + S_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
         rsp_basis_ff <= err_ff ? '0 : cell_q[0];
         rsp_deriv_ff <= err_ff ? '0 : dval_ff;
         rsp_sat_ff   <= err_ff ? 1'b0 : dsat_ff;
         rsp_err_ff   <= err_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_basis_value          = rsp_basis_ff;
   assign rsp_derivative_value     = rsp_deriv_ff;
   assign rsp_derivative_saturated = rsp_sat_ff;
   assign rsp_index_error          = rsp_err_ff;

   for (genvar m = 0; m < L; m++) begin : g_cell
      logic [NB_W:0] din;
      if (m == L - 1) begin : g_tail
         assign din = tail_in;
      end else begin : g_link
         assign din = {1'b0, cell_q[m+1]};
      end
      bsb_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .din      (din),
         .dout     (cell_q[m])
      );
   end

   bsb_div #(
      .NUM_W (DNUM_W),
      .DEN_W (DDEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_q)
   );

   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_stat.busy)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_basis_value == '0 && rsp_derivative_value == '0)
      else $error("index error beat carries data");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> rsp_basis_value <= ONE_Q30)
      else $error("basis above one");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_derivative_saturated |->
         rsp_derivative_value == 32'sh7fff_ffff || rsp_derivative_value == 32'sh8000_0000)
      else $error("saturation flag without clipped value");

endmodule

[bench/testbench.sv]
// self-checking testbench for the b-spline basis and derivative evaluator
module testbench;
   import bsb_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam longint Q30_ONE = 64'd1 << 30;

   typedef struct {
      logic [30:0] basis;
      logic signed [31:0] slope;
      logic slope_sat;
      logic index_err;
   } basis_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = ACT_LOAD;
   logic [4:0] req_knot_slot = '0;
   logic signed [31:0] req_knot_value = '0;
   logic [4:0] req_basis_index = '0;
   logic signed [31:0] req_point = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [30:0] rsp_basis_value;
   logic signed [31:0] rsp_derivative_value;
   logic rsp_derivative_saturated;
   logic rsp_index_error;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_DEGREE;
   logic [5:0] csr_write_data = '0;

   logic signed [31:0] knot_shadow [0:31];
   logic [1:0] degree_reg = 2'd3;
   logic [5:0] knot_count_reg = 6'd32;
   basis_rsp_type pending_basis [$];
   int errors = 0;
   int loads_sent = 0;
   int evals_sent = 0;
   int index_errs_seen = 0;
   int sats_seen = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   longint cycles = 0;

   bspline_basis_and_derivative i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic longint knot_weight(longint num, longint den);
      longint n, d;
      if (num == 0 || ((num < 0) != (den < 0))) return 0;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      if (n >= d) return Q30_ONE;
      return (n << 30) / d;
   endfunction

   function automatic longint slope_term(longint p, longint nq, longint den);
      longint num;
      num = (p * nq) << (2 * 16 - 30);
      return num / den;
   endfunction

   function automatic basis_rsp_type predict_basis(logic [4:0] idx, logic signed [31:0] pt);
      basis_rsp_type r;
      longint nb [0:4];
      longint k [0:31];
      longint p, kc, i, u, a, b, c, e, s, prev0, prev1, den1, den2, slope;
      r = '{default: '0};
      prev0 = 0;
      prev1 = 0;
      slope = 0;
      p = degree_reg;
      kc = knot_count_reg > 32 ? 32 : knot_count_reg;
      i = idx;
      u = pt;
      for (int m = 0; m < 32; m++) k[m] = knot_shadow[m];
      if (i + p + 1 >= kc) begin
         r.index_err = 1'b1;
         return r;
      end
      for (int j = 0; j <= p; j++)
         nb[j] = (k[i+j] <= u && u < k[i+j+1]) ? Q30_ONE : 0;
      for (int d = 1; d <= p; d++) begin
         if (d == p) begin
            prev0 = nb[0];
            prev1 = nb[1];
         end
         for (int j = 0; j + d <= p; j++) begin
            a = k[i+j];
            b = k[i+j+d];
            c = k[i+j+1];
            e = k[i+j+d+1];
            s = 0;
            if (b - a != 0) s += (knot_weight(u - a, b - a) * nb[j]) >> 30;
            if (e - c != 0) s += (knot_weight(e - u, e - c) * nb[j+1]) >> 30;
            nb[j] = s > Q30_ONE ? Q30_ONE : s;
         end
      end
      if (p > 0) begin
         den1 = k[i+p] - k[i];
         den2 = k[i+p+1] - k[i+1];
         if (den1 != 0) slope += slope_term(p, prev0, den1);
         if (den2 != 0) slope -= slope_term(p, prev1, den2);
         if (slope > 64'sd2147483647) begin
            slope = 64'sd2147483647;
            r.slope_sat = 1'b1;
         end else if (slope < -64'sd2147483648) begin
            slope = -64'sd2147483648;
            r.slope_sat = 1'b1;
         end
      end
      r.basis = nb[0][30:0];
      r.slope = slope[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   // result checker
   always @(posedge clock) begin
      basis_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_basis.size() == 0) begin
            report_mismatch("result beat with nothing expected", 1, 0);
         end else begin
            want = pending_basis.pop_front();
            if (rsp_basis_value !== want.basis)
               report_mismatch("basis_value", rsp_basis_value, want.basis);
            if (rsp_derivative_value !== want.slope)
               report_mismatch("derivative_value", rsp_derivative_value, want.slope);
            if (rsp_derivative_saturated !== want.slope_sat)
               report_mismatch("derivative_saturated", rsp_derivative_saturated,
                               want.slope_sat);
            if (rsp_index_error !== want.index_err)
               report_mismatch("index_error", rsp_index_error, want.index_err);
            if (want.index_err) index_errs_seen++;
            if (want.slope_sat) sats_seen++;
         end
      end
   end

   // receiver side
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(logic act, logic [4:0] slot, logic signed [31:0] kval,
                            logic [4:0] idx, logic signed [31:0] pt);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_knot_slot <= slot;
      req_knot_value <= kval;
      req_basis_index <= idx;
      req_point <= pt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == ACT_LOAD) begin
         knot_shadow[slot] = kval;
         loads_sent++;
      end else begin
         pending_basis.push_back(predict_basis(idx, pt));
         evals_sent++;
      end
   endtask

   task automatic load_knot(int slot, logic signed [31:0] kval);
      send_beat(ACT_LOAD, slot[4:0], kval, 5'($urandom), $urandom);
   endtask

   task automatic eval_at(int idx, logic signed [31:0] pt);
      send_beat(ACT_EVAL, 5'($urandom), $urandom, idx[4:0], pt);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_basis.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [5:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DEGREE) degree_reg = data[1:0];
      else knot_count_reg = data;
      @(posedge clock);
   endtask

   task automatic set_config(int deg, int kc);
      wait_idle();
      write_csr(CSR_DEGREE, {4'($urandom), 2'(deg)});
      write_csr(CSR_KNOT_COUNT, 6'(kc));
   endtask

   // knot table shapes: sorted, repeated, tightly spaced, unsorted
   task automatic fill_table(int shape);
      logic signed [31:0] v;
      v = -$signed(32'($urandom_range(0, 32'h3fff_ffff)));
      for (int s = 0; s < 32; s++) begin
         case (shape)
            0: v = v + $urandom_range(0, 32'h01ff_ffff);
            1: v = v + ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 32'h0010_0000));
            2: v = v + $urandom_range(0, 3);
            default: v = $urandom;
         endcase
         load_knot(s, v);
      end
   endtask

   function automatic logic signed [31:0] pick_point(int idx);
      int lo, hi;
      lo = idx > 31 ? 31 : idx;
      hi = idx + 4 > 31 ? 31 : idx + 4;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return knot_shadow[$urandom_range(lo, hi)];
         2: return knot_shadow[$urandom_range(lo, hi)] - 1;
         default:
            return knot_shadow[lo] + $signed(32'($urandom_range(0, 32'h7fff_ffff)))
                   % ((knot_shadow[hi] - knot_shadow[lo] + 1) | 1);
      endcase
   endfunction

   task automatic test_directed();
      for (int s = 0; s < 32; s++)
         load_knot(s, s < 4 ? 32'sd0 : (s < 20 ? (s - 4) * 32'sd65536 : 32'sd1048576 + s));
      load_knot(31, 32'h7fff_ffff);
      eval_at(0, 32'sd0);
      eval_at(4, 32'sd70000);
      eval_at(6, 32'sd131072);
      eval_at(10, 32'h8000_0000);
      eval_at(10, 32'h7fff_ffff);
      eval_at(28, 32'sd0);
      eval_at(31, 32'sd0);
      eval_at(19, 32'sd1048600);
      eval_at(24, 32'sd1048600);
      set_config(0, 32);
      eval_at(5, 32'sd65536);
      eval_at(31, 32'sd65536);
      set_config(1, 2);
      eval_at(0, 32'sd0);
      set_config(2, 63);
      eval_at(8, 32'sd300000);
      eval_at(29, 32'sd300000);
      set_config(3, 5);
      eval_at(0, 32'sd1);
      eval_at(1, 32'sd1);
   endtask

   task automatic test_random_phases();
      int kc, deg, n;
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 8) quiet = 1'b1;
         wait_idle();
         fill_table(ph % 4);
         deg = $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0: kc = 32;
            1: kc = $urandom_range(33, 63);
            2: kc = $urandom_range(2, 8);
            default: kc = $urandom_range(2, 32);
         endcase
         set_config(deg, kc);
         n = $urandom_range(75, 95);
         for (int k = 0; k < n; k++) begin
            int idx;
            idx = $urandom_range(0, 10) == 0 ? $urandom_range(0, 31)
                  : $urandom_range(0, kc > deg + 2 && kc <= 32 ? kc - deg - 2 : 28);
            if ($urandom_range(0, 15) == 0) load_knot($urandom_range(0, 31), $urandom);
            else eval_at(idx, pick_point(idx));
         end
      end
   endtask

   task automatic test_backpressure();
      set_config(3, 32);
      fill_table(0);
      hold_request = 8000;
      for (int k = 0; k < 6; k++) eval_at(k, pick_point(k));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phases();
      wait_idle();
      repeat (50) @(posedge clock);
      $display("covered %0d knot loads and %0d evaluations over degrees 0-3", loads_sent,
               evals_sent);
      $display("seen %0d index errors and %0d saturated derivatives", index_errs_seen,
               sats_seen);
      if (errors == 0 && pending_basis.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
